/* rtl/core/gfrt_pkg.sv */
`timescale 1ns / 1ps

package gfrt_pkg;

    localparam int ByteW       = 8;
    localparam int SampleW     = 16;
    localparam int AccW        = 26;
    localparam int SpeedW      = 13;
    localparam int LimitW      = 12;
    localparam int LeakShift   = 8;
    localparam int TargetShift = 12;
    localparam int CfgIdxW     = 2;
    localparam int CfgDataW    = 16;
    localparam int InDataW     = 8;
    localparam int OutDataW    = 32;

    // Frame delimiter characters.
    localparam logic [ByteW-1:0] CHAR_Y       = 8'h79;
    localparam logic [ByteW-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [ByteW-1:0] CHAR_Z       = 8'h7A;
    localparam logic [ByteW-1:0] CHAR_NEWLINE = 8'h0A;

    // Register reset values.
    localparam logic signed [SampleW-1:0] Y_OFFSET_RESET = -16'sd89;
    localparam logic signed [SampleW-1:0] Z_OFFSET_RESET = 16'sd218;
    localparam logic [LimitW-1:0]         LIMIT_RESET    = 12'd80;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_Y_OFFSET  = 2'd0,
        CFG_Z_OFFSET  = 2'd1,
        CFG_RPM_LIMIT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PARSE_IDLE    = 3'd0,
        PARSE_Y_HI    = 3'd1,
        PARSE_Y_LO    = 3'd2,
        PARSE_COMMA   = 3'd3,
        PARSE_Z       = 3'd4,
        PARSE_Z_HI    = 3'd5,
        PARSE_Z_LO    = 3'd6,
        PARSE_NEWLINE = 3'd7
    } parse_state_t;

    typedef struct packed {
        logic signed [SampleW-1:0] y_sample;
        logic signed [SampleW-1:0] z_sample;
    } frame_t;

    typedef struct packed {
        logic signed [SampleW-1:0] y_offset;
        logic signed [SampleW-1:0] z_offset;
        logic [LimitW-1:0]         rpm_limit;
    } cfg_t;

    // Handshake between the frame queue and its neighbors.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

/* rtl/core/gyro_frame_rate_target.sv */
`timescale 1ns / 1ps

// Channel     Direction  Handshake                    Payload
// s_axis      in         s_axis_tvalid/s_axis_tready  tdata[7:0] rx_byte
// m_axis      out        m_axis_tvalid/m_axis_tready  tdata[12:0] y, [25:13] z speeds
// cfg         in         cfg_we (no ready)            cfg_index, cfg_wdata
//
// One received byte is taken every cycle while the frame queue has room.
// The closing newline writes the frame into the queue; a pop then updates the
// accumulators, and when the middle stage advances the clamped result is
// registered into the output register and offered.
// Reset clears the parser, queue, accumulators and valid flags and reloads the config.
// A stalled output holds the back end; the parser keeps taking bytes until
// two finished frames wait in the queue.

module gyro_frame_rate_target (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] rx_byte
    input  logic [gfrt_pkg::InDataW-1:0]      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [12:0] y_target_speed, [25:13] z_target_speed, [31:26] zero
    output logic [gfrt_pkg::OutDataW-1:0]     m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [gfrt_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [gfrt_pkg::CfgDataW-1:0]     cfg_wdata
);
    import gfrt_pkg::*;

    // Configuration registers; bits above a register's width are dropped.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.y_offset  <= Y_OFFSET_RESET;
            cfg_reg.z_offset  <= Z_OFFSET_RESET;
            cfg_reg.rpm_limit <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_Y_OFFSET:  cfg_reg.y_offset  <= $signed(cfg_wdata);
                CFG_Z_OFFSET:  cfg_reg.z_offset  <= $signed(cfg_wdata);
                CFG_RPM_LIMIT: cfg_reg.rpm_limit <= cfg_wdata[LimitW-1:0];
                default:       ;
            endcase
        end
    end

    // Front end: frame parser. It pushes one complete frame per newline.
    logic          push;
    frame_t        push_frame;
    frame_t        q_frame;
    logic          pop;
    queue_status_t q_status;

    gfrt_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .rx_byte    (s_axis_tdata[ByteW-1:0]),
        .queue_full (q_status.full),
        .push       (push),
        .push_frame (push_frame)
    );

    // Two-entry queue that decouples the parser from the integrators.
    gfrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (q_frame),
        .status     (q_status)
    );

    // Back end: leaky integrators, then clamp and negate into the output register.
    logic signed [SpeedW-1:0] y_speed;
    logic signed [SpeedW-1:0] z_speed;

    gfrt_leak u_leak (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_status       (q_status),
        .q_frame        (q_frame),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .y_target_speed (y_speed),
        .z_target_speed (z_speed)
    );

    assign m_axis_tdata = {{(OutDataW - 2*SpeedW){1'b0}}, z_speed, y_speed};

endmodule

/* rtl/core/gfrt_parse.sv */
`timescale 1ns / 1ps

module gfrt_parse (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  logic [gfrt_pkg::ByteW-1:0] rx_byte,
    input  logic                     queue_full,
    output logic                     push,
    output gfrt_pkg::frame_t         push_frame
);
    import gfrt_pkg::*;

    parse_state_t             state_reg, state_next;
    logic signed [SampleW-1:0] y_sample_reg, y_sample_next;
    logic signed [SampleW-1:0] z_sample_reg, z_sample_next;
    logic                      take;

    assign byte_ready = !queue_full;
    assign take       = byte_valid && byte_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PARSE_IDLE;
            y_sample_reg <= '0;
            z_sample_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            y_sample_reg <= y_sample_next;
            z_sample_reg <= z_sample_next;
        end
    end

    // Bytes of a sample arrive high byte first, so each shifts in from the right.
    always_comb
    begin
        state_next    = state_reg;
        y_sample_next = y_sample_reg;
        z_sample_next = z_sample_reg;
        push          = 1'b0;
        if (take)
        begin
            case (state_reg)
                PARSE_IDLE:
                    state_next = (rx_byte == CHAR_Y) ? PARSE_Y_HI : PARSE_IDLE;
                PARSE_Y_HI:
                begin
                    y_sample_next = {{(SampleW-ByteW){1'b0}}, rx_byte};
                    state_next    = PARSE_Y_LO;
                end
                PARSE_Y_LO:
                begin
                    y_sample_next = {y_sample_reg[ByteW-1:0], rx_byte};
                    state_next    = PARSE_COMMA;
                end
                PARSE_COMMA:
                    state_next = (rx_byte == CHAR_COMMA) ? PARSE_Z : PARSE_IDLE;
                PARSE_Z:
                    state_next = (rx_byte == CHAR_Z) ? PARSE_Z_HI : PARSE_IDLE;
                PARSE_Z_HI:
                begin
                    z_sample_next = {{(SampleW-ByteW){1'b0}}, rx_byte};
                    state_next    = PARSE_Z_LO;
                end
                PARSE_Z_LO:
                begin
                    z_sample_next = {z_sample_reg[ByteW-1:0], rx_byte};
                    state_next    = PARSE_NEWLINE;
                end
                default:
                begin
                    push       = (rx_byte == CHAR_NEWLINE);
                    state_next = PARSE_IDLE;
                end
            endcase
        end
    end

    assign push_frame.y_sample = y_sample_reg;
    assign push_frame.z_sample = z_sample_reg;

endmodule

/* rtl/core/gfrt_queue.sv */
`timescale 1ns / 1ps

module gfrt_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  gfrt_pkg::frame_t          push_frame,
    input  logic                      pop,
    output gfrt_pkg::frame_t          pop_frame,
    output gfrt_pkg::queue_status_t   status
);
    import gfrt_pkg::*;

    frame_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

    assign pop_frame    = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);

endmodule

/* rtl/core/gfrt_leak.sv */
`timescale 1ns / 1ps

module gfrt_leak (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gfrt_pkg::cfg_t              cfg,
    input  gfrt_pkg::queue_status_t     q_status,
    input  gfrt_pkg::frame_t            q_frame,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [gfrt_pkg::SpeedW-1:0] y_target_speed,
    output logic signed [gfrt_pkg::SpeedW-1:0] z_target_speed
);
    import gfrt_pkg::*;

    localparam int QuotW = AccW - TargetShift;
    localparam int CmpW  = (QuotW > LimitW + 1) ? QuotW + 1 : LimitW + 2;

    logic signed [AccW-1:0]   y_acc_reg, z_acc_reg;
    logic                     mid_valid_reg;
    logic                     out_valid_reg;
    logic signed [SpeedW-1:0] y_speed_reg, z_speed_reg;
    logic                     mid_advance;

    function automatic logic signed [AccW-1:0] leak(
        input logic signed [AccW-1:0]    acc,
        input logic signed [SampleW-1:0] sample,
        input logic signed [SampleW-1:0] offset
    );
        logic signed [AccW-1:0] sum;
        sum = acc + AccW'(sample) - AccW'(offset) - (acc >>> LeakShift);
        return sum;
    endfunction

    function automatic logic signed [SpeedW-1:0] target(
        input logic signed [AccW-1:0] acc,
        input logic [LimitW-1:0]      limit
    );
        logic signed [QuotW-1:0] quot;
        logic signed [CmpW-1:0]  v;
        logic signed [CmpW-1:0]  lim;
        logic signed [CmpW-1:0]  clamped;
        logic signed [CmpW-1:0]  negated;
        quot = acc[AccW-1:TargetShift];
        v    = CmpW'(quot);
        lim  = $signed(CmpW'(limit));
        if (v > lim)
            clamped = lim;
        else if (v < -lim)
            clamped = -lim;
        else
            clamped = v;
        negated = -clamped;
        return negated[SpeedW-1:0];
    endfunction

    assign mid_advance = mid_valid_reg && (!out_valid_reg || out_ready);
    assign pop         = q_status.valid && (!mid_valid_reg || mid_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_acc_reg     <= '0;
            z_acc_reg     <= '0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                y_acc_reg <= leak(y_acc_reg, q_frame.y_sample, cfg.y_offset);
                z_acc_reg <= leak(z_acc_reg, q_frame.z_sample, cfg.z_offset);
            end
            if (pop)
                mid_valid_reg <= 1'b1;
            else if (mid_advance)
                mid_valid_reg <= 1'b0;
            if (mid_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // The accumulators only move on a pop, which never overtakes the frame
    // waiting in the middle stage, so they still hold that frame's values here.
    always_ff @(posedge clk)
    begin
        if (mid_advance)
        begin
            y_speed_reg <= target(y_acc_reg, cfg.rpm_limit);
            z_speed_reg <= target(z_acc_reg, cfg.rpm_limit);
        end
    end

    assign out_valid      = out_valid_reg;
    assign y_target_speed = y_speed_reg;
    assign z_target_speed = z_speed_reg;

endmodule

/* rtl/core/gfrt_checker.sv */
`timescale 1ns / 1ps

module gfrt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gfrt_pkg::OutDataW-1:0] m_axis_tdata
);
    import gfrt_pkg::*;

    localparam logic [SpeedW-1:0] SpeedMostNeg = {1'b1, {(SpeedW-1){1'b0}}};

    // A result that is not taken stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction withdrawn while stalled");

    // A stalled result keeps its data.
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // The clamp keeps both speeds within the symmetric range.
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SpeedW-1:0] != SpeedMostNeg)
                       && (m_axis_tdata[2*SpeedW-1:SpeedW] != SpeedMostNeg))
        else $error("target speed outside the clamp range");

    // The queue can only fill while the output is being held back.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

endmodule

bind gyro_frame_rate_target gfrt_checker u_gfrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

import gfrt_pkg::*;

// One pair of speed targets, y and z, as the scoreboard expects them.
typedef struct packed {
    logic [SpeedW-1:0] y;
    logic [SpeedW-1:0] z;
} speed_pair_t;

// Tracks the frame parser and both leaky integrators, and holds the speed
// targets that accepted frames are due to produce, oldest first.
class speed_scoreboard;
    parse_state_t               pos;
    logic signed [SampleW-1:0]  y_smp;
    logic signed [SampleW-1:0]  z_smp;
    logic signed [AccW-1:0]     y_acc;
    logic signed [AccW-1:0]     z_acc;
    cfg_t                       cfg;
    speed_pair_t                expected_speeds[$];
    int                         errors;
    int                         bytes_seen;
    int                         frames_accepted;
    int                         results_checked;

    function new();
        pos             = PARSE_IDLE;
        y_smp           = '0;
        z_smp           = '0;
        y_acc           = '0;
        z_acc           = '0;
        cfg.y_offset    = Y_OFFSET_RESET;
        cfg.z_offset    = Z_OFFSET_RESET;
        cfg.rpm_limit   = LIMIT_RESET;
        errors          = 0;
        bytes_seen      = 0;
        frames_accepted = 0;
        results_checked = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CfgDataW-1:0] value);
        case (idx)
            CFG_Y_OFFSET:  cfg.y_offset  = value;
            CFG_Z_OFFSET:  cfg.z_offset  = value;
            CFG_RPM_LIMIT: cfg.rpm_limit = value[LimitW-1:0];
            default: ;
        endcase
    endfunction

    // acc + sample - offset - (acc >>> 8), wrapped to the accumulator width.
    function logic signed [AccW-1:0] leak_step(logic signed [AccW-1:0] acc,
                                               logic signed [SampleW-1:0] smp,
                                               logic signed [SampleW-1:0] ofs);
        int a;
        int sum;
        a   = acc;
        sum = a + smp - ofs - (a >>> LeakShift);
        return sum[AccW-1:0];
    endfunction

    function logic [SpeedW-1:0] speed_of(logic signed [AccW-1:0] acc);
        int v;
        int lim;
        v   = acc;
        v   = v >>> TargetShift;
        lim = {20'd0, cfg.rpm_limit};
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        v = -v;
        return v[SpeedW-1:0];
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
        speed_pair_t want;
        bytes_seen++;
        case (pos)
            PARSE_IDLE:    pos = (b == CHAR_Y) ? PARSE_Y_HI : PARSE_IDLE;
            PARSE_Y_HI:
            begin
                y_smp = {8'h00, b};
                pos   = PARSE_Y_LO;
            end
            PARSE_Y_LO:
            begin
                y_smp = {y_smp[7:0], b};
                pos   = PARSE_COMMA;
            end
            PARSE_COMMA:   pos = (b == CHAR_COMMA) ? PARSE_Z : PARSE_IDLE;
            PARSE_Z:       pos = (b == CHAR_Z) ? PARSE_Z_HI : PARSE_IDLE;
            PARSE_Z_HI:
            begin
                z_smp = {8'h00, b};
                pos   = PARSE_Z_LO;
            end
            PARSE_Z_LO:
            begin
                z_smp = {z_smp[7:0], b};
                pos   = PARSE_NEWLINE;
            end
            default:
            begin
                if (b == CHAR_NEWLINE)
                begin
                    y_acc  = leak_step(y_acc, y_smp, cfg.y_offset);
                    z_acc  = leak_step(z_acc, z_smp, cfg.z_offset);
                    want.y = speed_of(y_acc);
                    want.z = speed_of(z_acc);
                    expected_speeds.push_back(want);
                    frames_accepted++;
                end
                pos = PARSE_IDLE;
            end
        endcase
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [OutDataW-1:0] data);
        speed_pair_t       want;
        logic [SpeedW-1:0] got_y;
        logic [SpeedW-1:0] got_z;
        got_y = data[SpeedW-1:0];
        got_z = data[2*SpeedW-1:SpeedW];
        results_checked++;
        if (expected_speeds.size() == 0)
        begin
            report($sformatf("unexpected result y=%0d z=%0d",
                             $signed(got_y), $signed(got_z)));
            return;
        end
        want = expected_speeds.pop_front();
        if (got_y !== want.y)
            report($sformatf("y target %0d, expected %0d", $signed(got_y), $signed(want.y)));
        if (got_z !== want.z)
            report($sformatf("z target %0d, expected %0d", $signed(got_z), $signed(want.z)));
    endtask

    task flush_leftovers();
        speed_pair_t want;
        while (expected_speeds.size() != 0)
        begin
            want = expected_speeds.pop_front();
            report($sformatf("result y=%0d z=%0d never arrived",
                             $signed(want.y), $signed(want.z)));
        end
    endtask

    function int pending();
        return expected_speeds.size();
    endfunction
endclass

module tb;

    // Cycles waited after the last result before a register write; the result
    // path runs through the queue, the accumulators and the output register.
    localparam int SettleCycles = 6;
    // Length of the deliberate receiver hold-off in each phase.
    localparam int HoldOffCycles = 300;
    // Items per random phase; six phases give about 1500 items in all.
    localparam int PhaseItems = 250;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [InDataW-1:0]     s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OutDataW-1:0]    m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]     cfg_index     = '0;
    logic [CfgDataW-1:0]    cfg_wdata     = '0;

    speed_scoreboard        sb = new();

    // Percent chance per cycle that the sender or the receiver idles.
    int                     tx_idle_pct  = 0;
    int                     rx_idle_pct  = 0;
    // Remaining cycles of a forced receiver hold-off.
    int                     rx_hold_left = 0;
    int                     settings_used = 0;
    logic [ByteW-1:0]       chunk_bytes[$];

    gyro_frame_rate_target uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // The receiver decides its ready at every falling edge. A pending
    // hold-off overrides the random stalls, so the block has to back up.
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every output transaction is checked at the rising edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Offers one byte, optionally after a random gap, and waits for the
    // transaction. The task is entered and left at a falling edge.
    task send_byte(input logic [ByteW-1:0] b);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    // Stops offering bytes and waits until every expected result has come,
    // then lets the pipeline run empty. The limit only guards against a hang.
    task drain_results(input int limit);
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < limit)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SettleCycles) @(negedge clk);
    endtask

    // Writes all three registers on consecutive edges; only called while
    // the block is idle.
    task load_config(input logic [CfgDataW-1:0] y_ofs, input logic [CfgDataW-1:0] z_ofs,
                     input logic [CfgDataW-1:0] limit_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_Y_OFFSET;
        cfg_wdata <= y_ofs;
        @(negedge clk);
        sb.write_register(CFG_Y_OFFSET, y_ofs);
        cfg_index <= CFG_Z_OFFSET;
        cfg_wdata <= z_ofs;
        @(negedge clk);
        sb.write_register(CFG_Z_OFFSET, z_ofs);
        cfg_index <= CFG_RPM_LIMIT;
        cfg_wdata <= limit_word;
        @(negedge clk);
        sb.write_register(CFG_RPM_LIMIT, limit_word);
        cfg_we    <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Sample bytes lean toward the values that set or clear the sign bit.
    function logic [ByteW-1:0] sample_byte();
        case ($urandom_range(11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A byte that breaks a frame at a given slot. A 'y' is favored so that
    // the block must not treat it as the start of a new frame.
    function logic [ByteW-1:0] other_than(input logic [ByteW-1:0] wanted);
        logic [ByteW-1:0] x;
        x = ($urandom_range(3) == 0) ? CHAR_Y : 8'($urandom_range(255));
        while (x == wanted)
            x = 8'($urandom_range(255));
        return x;
    endfunction

    // One random phase. Most chunks are whole frames with random samples;
    // the rest are frames broken at the separator, at the 'z' or at the
    // final slot, and loose noise bytes while the parser is idle. Halfway
    // through, the receiver holds off while bytes keep coming; later the
    // sender pauses until all results are back.
    task run_phase(input int tx_pct, input int rx_pct, input int n_items);
        int kind;
        int sent;
        bit held;
        bit paused;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent        = 0;
        held        = 1'b0;
        paused      = 1'b0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            chunk_bytes.delete();
            if (kind < 93)
            begin
                chunk_bytes.push_back(CHAR_Y);
                chunk_bytes.push_back(sample_byte());
                chunk_bytes.push_back(sample_byte());
                if (kind >= 75 && kind < 82)
                begin
                    chunk_bytes.push_back(other_than(CHAR_COMMA));
                end
                else
                begin
                    chunk_bytes.push_back(CHAR_COMMA);
                    if (kind >= 75 && kind < 88)
                    begin
                        chunk_bytes.push_back(other_than(CHAR_Z));
                    end
                    else
                    begin
                        chunk_bytes.push_back(CHAR_Z);
                        chunk_bytes.push_back(sample_byte());
                        chunk_bytes.push_back(sample_byte());
                        chunk_bytes.push_back((kind >= 88) ? other_than(CHAR_NEWLINE)
                                                           : CHAR_NEWLINE);
                    end
                end
                sent += chunk_bytes.size();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    chunk_bytes.push_back(8'($urandom_range(255)));
            end
            foreach (chunk_bytes[i])
                send_byte(chunk_bytes[i]);
            if (!held && sent >= n_items / 2)
            begin
                rx_hold_left = HoldOffCycles;
                held         = 1'b1;
            end
            if (!paused && sent >= (3 * n_items) / 4)
            begin
                drain_results(100000);
                paused = 1'b1;
            end
        end
        drain_results(100000);
    endtask

    // Directed frames: a complete frame with both sample extremes, a wrong
    // separator, a wrong 'z' byte, and a full frame whose last byte is not
    // a newline. Each broken frame ends in a 'z', a separator or a 'y' that must
    // not start a new frame by itself.
    logic [ByteW-1:0] directed_bytes[25] = '{
        CHAR_Y, 8'h7F, 8'hFF, CHAR_COMMA, CHAR_Z, 8'h80, 8'h00, CHAR_NEWLINE,
        CHAR_Y, 8'h80, 8'h00, CHAR_Z,
        CHAR_Y, 8'h12, 8'h34, CHAR_COMMA, CHAR_COMMA,
        CHAR_Y, 8'h01, 8'h02, CHAR_COMMA, CHAR_Z, 8'h03, 8'h04, CHAR_Y
    };

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bytes run against the reset register values, unthrottled.
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain_results(100000);

        // Sender mostly busy, receiver mostly stalled.
        load_config(16'h0000, 16'h0000, 16'h0FFF);
        run_phase(12, 88, PhaseItems);
        load_config(16'h8000, 16'h7FFF, 16'h0000);
        run_phase(12, 88, PhaseItems);

        // Sender mostly idle, receiver mostly ready. The limit word has its
        // upper bits set, which the register must drop.
        load_config(16'h7FFF, 16'h8000, 16'hFFFF);
        run_phase(88, 12, PhaseItems);
        load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)));
        run_phase(88, 12, PhaseItems);

        // No idling on either side.
        load_config(16'hFFA7, 16'h00DA, 16'h0050);
        run_phase(0, 0, PhaseItems);
        load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(4095)));
        run_phase(0, 0, PhaseItems);

        drain_results(20000);
        sb.flush_leftovers();

        $display("Sent %0d bytes under %0d register settings, with both stall patterns,",
                 sb.bytes_seen, settings_used + 1);
        $display("a receiver hold-off and idle pauses; %0d frames gave %0d checked results.",
                 sb.frames_accepted, sb.results_checked);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake; a correct run ends far sooner.
    initial
    begin
        #5_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
